@@ src/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// dll_pkg
// Operation and status codes and controller commands for the list manager.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam logic [3:0] OP_HPUSH  = 4'd0;
  localparam logic [3:0] OP_TPUSH  = 4'd1;
  localparam logic [3:0] OP_HPOP   = 4'd2;
  localparam logic [3:0] OP_TPOP   = 4'd3;
  localparam logic [3:0] OP_HPEEK  = 4'd4;
  localparam logic [3:0] OP_TPEEK  = 4'd5;
  localparam logic [3:0] OP_INS_B  = 4'd6;
  localparam logic [3:0] OP_INS_A  = 4'd7;
  localparam logic [3:0] OP_REMOVE = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADREF = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic read;     // read links and data of target node
    logic exec;     // apply the update
    logic done;     // result handed to output register
  } dll_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dll_stat_t;

endpackage

@@ src/doubly_linked_list_manager.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Doubly linked list in a bounded node pool with a spare list.
// ----------------------------------------------------------------------------
// Each operation goes from accepted input beat to result beat through
// capture, a registered read of the target node and the spare head, an
// update that rewrites up to three nodes' links, and the output register load.
// A new beat is accepted only after the previous result has been loaded into
// the output register, so only one operation is in flight at a time. Node
// memories need no clearing after reset.
module doubly_linked_list_manager #(
  parameter int NODES      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [7:0]  node_ref,
  input  logic [31:0] data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_out,
  output logic [7:0]  node_out,
  output logic [1:0]  status,
  output logic [8:0]  count_out
);
  import dll_pkg::*;

  dll_cmd_t  cmd;
  dll_stat_t stat;

  dll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  dll_datapath #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(operation), .node_ref(node_ref), .data_in(data_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_out(data_out), .node_out(node_out), .status(status),
    .count_out(count_out)
  );

endmodule

@@ src/dll_datapath.sv @@
// ----------------------------------------------------------------------------
// dll_datapath
// Node memories, list pointers, allocator and the output register.
// ----------------------------------------------------------------------------
module dll_datapath #(
  parameter int NODES      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dll_pkg::dll_cmd_t   cmd,
  output dll_pkg::dll_stat_t  stat,
  input  logic [3:0]          operation,
  input  logic [7:0]          node_ref,
  input  logic [31:0]         data_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         data_out,
  output logic [7:0]          node_out,
  output logic [1:0]          status,
  output logic [8:0]          count_out
);
  import dll_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NONE = PW'(NODES);

  // node memories
  logic [PW-1:0]         next_mem [NODES];
  logic [PW-1:0]         prev_mem [NODES];
  logic [DATA_WIDTH-1:0] data_mem [NODES];
  logic [NODES-1:0]      in_list;

  logic [PW-1:0] head_ptr, tail_ptr, list_size, spare_head, spare_count, fresh_count;

  // captured beat
  logic [3:0]            op;
  logic [7:0]            ref_q;
  logic [DATA_WIDTH-1:0] din;

  // registered memory reads
  logic [PW-1:0]         rd_next, rd_prev, sp_next;
  logic [DATA_WIDTH-1:0] rd_data;

  logic ref_ok;
  logic is_ins, is_end, is_hend, ins_any;
  logic [PW-1:0] end_ptr, tgt;

  assign ref_ok  = (32'(node_ref) < NODES) && in_list[AW'(node_ref)];
  assign is_ins  = (op == OP_INS_B) || (op == OP_INS_A);
  assign ins_any = (op == OP_HPUSH) || (op == OP_TPUSH) || is_ins;
  assign is_end  = (op == OP_HPOP) || (op == OP_TPOP) || (op == OP_HPEEK) || (op == OP_TPEEK);
  assign is_hend = (op == OP_HPOP) || (op == OP_HPEEK);
  assign end_ptr = is_hend ? head_ptr : tail_ptr;
  assign tgt     = is_end ? end_ptr : PW'(ref_q);

  logic ref_in;

  // capture and check beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= operation;
      ref_q  <= node_ref;
      din    <= DATA_WIDTH'(data_in);
      ref_in <= ref_ok;
    end
  end

  // read target node and spare head
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_next <= next_mem[tgt[AW-1:0]];
      rd_prev <= prev_mem[tgt[AW-1:0]];
      rd_data <= data_mem[tgt[AW-1:0]];
      sp_next <= next_mem[spare_head[AW-1:0]];
    end
  end

  // execute
  logic          have_spare, have_fresh;
  logic [PW-1:0] nn, p, q, u;
  logic [1:0]    st;
  logic [31:0]   dres;
  logic          do_link, do_unlink;

  always_comb begin
    have_spare = (spare_count != '0) && (spare_head < NONE);
    have_fresh = fresh_count < NONE;
    nn = have_spare ? spare_head : fresh_count;
    st = ST_OK;
    dres = '0;
    do_link = 1'b0;
    do_unlink = 1'b0;
    u = tgt;
    p = NONE;
    q = NONE;
    if (ins_any) begin
      if (is_ins && !ref_in) st = ST_BADREF;
      else if (!have_spare && !have_fresh) st = ST_FULL;
      else do_link = 1'b1;
      case (op)
        OP_HPUSH: begin p = NONE; q = head_ptr; end
        OP_TPUSH: begin p = tail_ptr; q = NONE; end
        OP_INS_B: begin p = rd_prev; q = PW'(ref_q); end
        default: begin p = PW'(ref_q); q = rd_next; end
      endcase
    end else if (is_end) begin
      if (list_size == '0 || end_ptr >= NONE) st = ST_EMPTY;
      else begin
        dres = 32'(rd_data);
        do_unlink = (op == OP_HPOP) || (op == OP_TPOP);
      end
    end else if (op == OP_REMOVE) begin
      if (!ref_in) st = ST_BADREF;
      else begin
        dres = 32'(rd_data);
        do_unlink = 1'b1;
      end
    end
    if (do_unlink) begin
      p = rd_prev;
      q = rd_next;
    end
  end

  // list update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_list     <= '0;
      head_ptr    <= NONE;
      tail_ptr    <= NONE;
      list_size   <= '0;
      spare_head  <= NONE;
      spare_count <= '0;
      fresh_count <= '0;
    end else if (cmd.exec) begin
      if (do_link) begin
        data_mem[nn[AW-1:0]] <= din;
        prev_mem[nn[AW-1:0]] <= p;
        next_mem[nn[AW-1:0]] <= q;
        if (p < NONE) next_mem[p[AW-1:0]] <= nn; else head_ptr <= nn;
        if (q < NONE) prev_mem[q[AW-1:0]] <= nn; else tail_ptr <= nn;
        in_list[nn[AW-1:0]] <= 1'b1;
        list_size <= list_size + 1'b1;
        if (have_spare) begin
          spare_head  <= sp_next;
          spare_count <= spare_count - 1'b1;
        end else begin
          fresh_count <= fresh_count + 1'b1;
        end
      end else if (do_unlink) begin
        if (p < NONE) next_mem[p[AW-1:0]] <= q; else head_ptr <= q;
        if (q < NONE) prev_mem[q[AW-1:0]] <= p; else tail_ptr <= p;
        next_mem[u[AW-1:0]] <= spare_head;
        spare_head  <= u;
        spare_count <= spare_count + 1'b1;
        in_list[u[AW-1:0]] <= 1'b0;
        list_size <= list_size - 1'b1;
      end
    end
  end

  // output register, filled in the done step from the staged result and live count
  logic [31:0] dres_q;
  logic [7:0]  nout_q;
  logic [1:0]  st_q;
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dres_q <= dres;
      nout_q <= do_link ? 8'(nn) : 8'd0;
      st_q   <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      data_out  <= dres_q;
      node_out  <= nout_q;
      status    <= st_q;
      count_out <= 9'(list_size);
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  // list count never exceeds the pool
  a_count: assert property (@(posedge clk) disable iff (rst) list_size <= NONE)
    else $error("list count beyond pool");
  // never-used counter only grows
  a_fresh: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fresh_count >= $past(fresh_count))
    else $error("fresh counter went down");
  // empty list has no head
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (list_size == '0) |-> (head_ptr == NONE && tail_ptr == NONE))
    else $error("empty list with head");

endmodule

@@ src/dll_ctrl.sv @@
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer: capture, read, execute, deliver.
// ----------------------------------------------------------------------------
module dll_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dll_pkg::dll_stat_t stat,
  output dll_pkg::dll_cmd_t  cmd
);
  import dll_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: if (!stat.out_busy) begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // one command at a time
  a_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("overlapping commands");
  // a load is always followed by a read
  a_seq: assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.read)
    else $error("read did not follow load");
  // exec follows read
  a_exec: assert property (@(posedge clk) disable iff (rst) cmd.read |=> cmd.exec)
    else $error("exec did not follow read");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked list manager: a directed table, a
// pool-fill and drain pass, and random phases with idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import dll_pkg::*;

  localparam int       POOL      = 256;
  localparam logic [8:0] NIL     = 9'd256;
  localparam int       LIMIT     = 600000;
  localparam int       RAND_ITEMS = 330;

  typedef struct {
    logic [31:0] data;
    logic [7:0]  node;
    logic [1:0]  st;
    logic [8:0]  cnt;
  } list_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [7:0]  ref_id;
    logic [31:0] din;
    bit          typed;
    list_result_t res;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  operation = '0;
  logic [7:0]  node_ref = '0;
  logic [31:0] data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] data_out;
  logic [7:0]  node_out;
  logic [1:0]  status;
  logic [8:0]  count_out;

  doubly_linked_list_manager dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .node_ref(node_ref), .data_in(data_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_out(data_out), .node_out(node_out), .status(status),
    .count_out(count_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the list state
  logic [8:0]  nxt [POOL];
  logic [8:0]  prv [POOL];
  logic [31:0] word [POOL];
  bit          linked [POOL];
  logic [8:0]  head, tail, cnt, spare, spare_cnt, fresh;

  list_result_t pending_results[$];
  int  errors = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  full_seen = 0;
  int  cycles = 0;
  int  idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  function automatic logic [8:0] take_node();
    logic [8:0] n;
    if (spare_cnt > 0 && spare < NIL) begin
      n = spare;
      spare = nxt[n[7:0]];
      spare_cnt--;
      return n;
    end
    if (fresh < NIL) begin
      n = fresh;
      fresh++;
      return n;
    end
    return NIL;
  endfunction

  function automatic logic [31:0] unlink(logic [8:0] n);
    logic [8:0] p, q;
    p = prv[n[7:0]];
    q = nxt[n[7:0]];
    if (p < NIL) nxt[p[7:0]] = q; else head = q;
    if (q < NIL) prv[q[7:0]] = p; else tail = p;
    nxt[n[7:0]] = spare;
    spare = n;
    spare_cnt++;
    linked[n[7:0]] = 1'b0;
    cnt--;
    return word[n[7:0]];
  endfunction

  // predicted result of one operation, updating the shadow state
  function automatic list_result_t list_apply(logic [3:0] op, logic [7:0] r,
                                              logic [31:0] din);
    list_result_t res;
    logic [8:0] n, p, q, e;
    bit ok;
    res = '{default: '0};
    ok = linked[r];
    case (op)
      OP_HPUSH, OP_TPUSH, OP_INS_B, OP_INS_A: begin
        if ((op == OP_INS_B || op == OP_INS_A) && !ok) res.st = ST_BADREF;
        else begin
          n = take_node();
          if (n == NIL) res.st = ST_FULL;
          else begin
            if (op == OP_HPUSH) begin p = NIL; q = head; end
            else if (op == OP_TPUSH) begin p = tail; q = NIL; end
            else if (op == OP_INS_B) begin p = prv[r]; q = {1'b0, r}; end
            else begin p = {1'b0, r}; q = nxt[r]; end
            word[n[7:0]] = din;
            prv[n[7:0]] = p;
            nxt[n[7:0]] = q;
            if (p < NIL) nxt[p[7:0]] = n; else head = n;
            if (q < NIL) prv[q[7:0]] = n; else tail = n;
            linked[n[7:0]] = 1'b1;
            cnt++;
            res.node = n[7:0];
          end
        end
      end
      OP_HPOP, OP_TPOP, OP_HPEEK, OP_TPEEK: begin
        e = (op == OP_HPOP || op == OP_HPEEK) ? head : tail;
        if (cnt == 0 || e >= NIL) res.st = ST_EMPTY;
        else if (op == OP_HPOP || op == OP_TPOP) res.data = unlink(e);
        else res.data = word[e[7:0]];
      end
      OP_REMOVE: begin
        if (!ok) res.st = ST_BADREF;
        else res.data = unlink({1'b0, r});
      end
      default: ;
    endcase
    res.cnt = cnt;
    return res;
  endfunction

  // one input beat; prediction is made when the beat is taken
  task automatic send_op(logic [3:0] op, logic [7:0] r, logic [31:0] din,
                         bit typed, list_result_t typed_res);
    list_result_t res;
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 53) ||
        (idle_mode == 3 && $urandom_range(99) < 14))
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    node_ref  <= r;
    data_in   <= din;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = list_apply(op, r, din);
    if (res.st == ST_FULL) full_seen++;
    pending_results.push_back(typed ? typed_res : res);
    beats_in++;
  endtask

  function automatic logic [7:0] pick_ref();
    logic [7:0] r;
    if ($urandom_range(99) < 85 && cnt > 0 && fresh > 0)
      for (int k = 0; k < 16; k++) begin
        r = 8'($urandom_range(fresh - 1));
        if (linked[r]) return r;
      end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op();
    int w;
    logic [3:0] op;
    w = $urandom_range(99);
    if (w < 30) op = $urandom_range(1) ? OP_TPUSH : OP_HPUSH;
    else if (w < 42) op = $urandom_range(1) ? OP_TPOP : OP_HPOP;
    else if (w < 52) op = $urandom_range(1) ? OP_TPEEK : OP_HPEEK;
    else if (w < 77) op = $urandom_range(1) ? OP_INS_A : OP_INS_B;
    else if (w < 95) op = OP_REMOVE;
    else op = 4'($urandom_range(9, 15));
    send_op(op, pick_ref(), pick_word(), 1'b0, '{default: '0});
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // directed table: typed expectations only where obvious
  table_row_t dir_rows[$];

  task automatic add_row(logic [3:0] op, logic [7:0] r, logic [31:0] din, bit typed,
                         logic [31:0] d, logic [7:0] n, logic [1:0] st,
                         logic [8:0] c);
    table_row_t row;
    row.op = op; row.ref_id = r; row.din = din; row.typed = typed;
    row.res.data = d; row.res.node = n; row.res.st = st; row.res.cnt = c;
    dir_rows.push_back(row);
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      nxt[i] = '0; prv[i] = '0; word[i] = '0; linked[i] = 1'b0;
    end
    head = NIL; tail = NIL; spare = NIL;
    cnt = '0; spare_cnt = '0; fresh = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_HPOP,   8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_EMPTY,  9'd0);
    add_row(OP_TPOP,   8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_EMPTY,  9'd0);
    add_row(OP_HPEEK,  8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_EMPTY,  9'd0);
    add_row(OP_TPEEK,  8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_EMPTY,  9'd0);
    add_row(OP_REMOVE, 8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_BADREF, 9'd0);
    add_row(OP_INS_B,  8'd255, 32'h1234,      1'b1, 32'h0, 8'd0, ST_BADREF, 9'd0);
    add_row(4'd15,     8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0, 8'd0, ST_OK,     9'd0);
    add_row(OP_HPUSH,  8'd0,   32'hFFFF_FFFF, 1'b1, 32'h0, 8'd0, ST_OK,     9'd1);
    add_row(OP_TPUSH,  8'd0,   32'h0,         1'b1, 32'h0, 8'd1, ST_OK,     9'd2);
    add_row(OP_HPEEK,  8'd0,   32'h0,         1'b1, 32'hFFFF_FFFF, 8'd0, ST_OK, 9'd2);
    add_row(OP_TPEEK,  8'd0,   32'h0,         1'b1, 32'h0, 8'd0, ST_OK,     9'd2);
    add_row(OP_INS_A,  8'd0,   32'hA5A5_5A5A, 1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_INS_B,  8'd1,   32'h8000_0001, 1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_INS_A,  8'd200, 32'h1,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_REMOVE, 8'd2,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_REMOVE, 8'd2,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_HPUSH,  8'd0,   32'h7FFF_FFFF, 1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_INS_B,  8'd0,   32'h5555_5555, 1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_HPOP,   8'd0,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_TPOP,   8'd0,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(4'd9,      8'd0,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    add_row(OP_REMOVE, 8'd3,   32'h0,         1'b0, 32'h0, 8'd0, ST_OK, 9'd0);
    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].ref_id, dir_rows[i].din,
              dir_rows[i].typed, dir_rows[i].res);
    drain_wait();

    // fill the pool past its end, then insert and remove at the top handle
    idle_mode = 3;
    for (int i = 0; i < POOL + 4; i++)
      send_op($urandom_range(1) ? OP_TPUSH : OP_HPUSH, 8'd0, pick_word(),
              1'b0, '{default: '0});
    send_op(OP_INS_A, 8'd255, 32'h0, 1'b0, '{default: '0});
    send_op(OP_REMOVE, 8'd255, 32'h0, 1'b0, '{default: '0});
    send_op(OP_INS_B, 8'd255, 32'hFFFF_FFFF, 1'b0, '{default: '0});
    while (cnt > 0) begin
      if ($urandom_range(2) == 0)
        send_op($urandom_range(1) ? OP_TPOP : OP_HPOP, 8'd0, 32'h0, 1'b0,
                '{default: '0});
      else
        send_op(OP_REMOVE, pick_ref(), 32'h0, 1'b0, '{default: '0});
    end
    drain_wait();

    // random phases over all idling styles
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      if (ph == 1) begin
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) random_op();
        hold_req = 1'b0;
      end
      for (int i = 0; i < RAND_ITEMS; i++) random_op();
      drain_wait();
    end

    idle_mode = 0;
    repeat (20) @(posedge clk);
    $display("run covered %0d beats in, %0d results, %0d pool-exhausted results",
             beats_in, beats_out, full_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // result checking
  always @(posedge clk) begin
    list_result_t want;
    if (out_valid && out_ready && !rst) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat data %h node %h status %0d count %0d",
                 $time, data_out, node_out, status, count_out);
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data) begin
          errors++;
          $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
        end
        if (node_out !== want.node) begin
          errors++;
          $display("%0t: node_out expected %h actual %h", $time, want.node, node_out);
        end
        if (status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        end
        if (count_out !== want.cnt) begin
          errors++;
          $display("%0t: count_out expected %0d actual %0d", $time, want.cnt, count_out);
        end
      end
    end
  end

  // receiver stalls, long hold counted in cycles
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    if (hold_left > 1 || (hold_req && hold_left == 0)) out_ready <= 1'b0;
    else if (idle_mode == 2) out_ready <= ($urandom_range(99) >= 53);
    else if (idle_mode == 3) out_ready <= ($urandom_range(99) >= 14);
    else out_ready <= 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
src/dll_pkg.sv
src/dll_datapath.sv
src/dll_ctrl.sv
src/doubly_linked_list_manager.sv
sim/testbench.sv
